### hw/rtl/sha1bs_pkg.sv
`default_nettype none

package sha1bs_pkg;

  // request codes carried in req_type
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_FINAL = 1'b1;

  // initial chaining value, word 0 at index 0
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // round constants
  localparam logic [31:0] SHA1_K0 = 32'h5a827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ed9eba1;
  localparam logic [31:0] SHA1_K2 = 32'h8f1bbcdc;
  localparam logic [31:0] SHA1_K3 = 32'hca62c1d6;

  localparam int unsigned ROUNDS = 80;

  // one block of work for the compression core
  typedef struct packed {
    logic              last;   // final block of a message: emit digest, restore IV
    logic [15:0][31:0] words;  // word 0 holds message bytes 0..3, big-endian
  } sha1bs_job_t;

  // front end status, seen at the top level
  typedef struct packed {
    logic len_pend;     // length block still to be queued
    logic block_empty;  // no bytes pending in the block buffer
  } sha1bs_front_stat_t;

  typedef enum logic {
    FRONT_TAKE,
    FRONT_LEN
  } sha1bs_front_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINISH
  } sha1bs_core_state_t;

  // round function, chosen by round number
  function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = SHA1_K0;
    end else if (rnd < 7'd40) begin
      k = SHA1_K1;
    end else if (rnd < 7'd60) begin
      k = SHA1_K2;
    end else begin
      k = SHA1_K3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sha1bs_if.sv
`default_nettype none

// request channel: one byte or a finalize per beat
interface sha1bs_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// digest channel: one 160-bit digest per beat
interface sha1bs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_high;
  logic [63:0] digest_middle;
  logic [31:0] digest_low;

  modport source (output valid, output digest_high, output digest_middle,
                  output digest_low, input ready);
  modport sink   (input valid, input digest_high, input digest_middle,
                  input digest_low, output ready);
endinterface

`default_nettype wire

### hw/rtl/sha1bs_front.sv
`default_nettype none

module sha1bs_front (
  input  logic                        clk,
  input  logic                        rst,
  sha1bs_in_if.sink                   req,
  input  logic                        q_full,
  output logic                        q_push,
  output sha1bs_pkg::sha1bs_job_t     q_job,
  output sha1bs_pkg::sha1bs_front_stat_t stat
);
  import sha1bs_pkg::*;

  sha1bs_front_state_t state, state_next;
  logic [15:0][31:0]   blk;
  logic [5:0]          n, n_next;
  logic [60:0]         total, total_next;

  logic        take;
  logic [3:0]  idx;
  logic [1:0]  lane;
  logic [31:0] cur_wd, byte_wd, pad_wd;
  logic [63:0] bit_len;
  logic [15:0][31:0] fill_words, pad_words, len_words;

  assign idx     = n[5:2];
  assign lane    = n[1:0];
  assign cur_wd  = blk[idx];
  assign bit_len = {total, 3'b000};
  assign take    = req.valid && req.ready;

  assign req.ready        = (state == FRONT_TAKE) && !q_full;
  assign stat.len_pend    = (state == FRONT_LEN);
  assign stat.block_empty = (n == 6'd0);

  // byte merged into its lane; lane 0 starts a fresh word
  always_comb begin
    byte_wd = cur_wd;
    pad_wd  = cur_wd;
    case (lane)
      2'd0: begin
        byte_wd = {req.data_byte, 24'h0};
        pad_wd  = {8'h80, 24'h0};
      end
      2'd1: begin
        byte_wd[23:16] = req.data_byte;
        pad_wd         = {cur_wd[31:24], 8'h80, 16'h0};
      end
      2'd2: begin
        byte_wd[15:8] = req.data_byte;
        pad_wd        = {cur_wd[31:16], 8'h80, 8'h0};
      end
      default: begin
        byte_wd[7:0] = req.data_byte;
        pad_wd       = {cur_wd[31:8], 8'h80};
      end
    endcase
  end

  // full block with this byte, padded block, and the length-only block
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      if (4'(j) == idx) begin
        fill_words[j] = byte_wd;
        pad_words[j]  = pad_wd;
      end else if (4'(j) > idx) begin
        fill_words[j] = blk[j];
        pad_words[j]  = 32'h0;
      end else begin
        fill_words[j] = blk[j];
        pad_words[j]  = blk[j];
      end
      len_words[j] = 32'h0;
    end
    len_words[14] = bit_len[63:32];
    len_words[15] = bit_len[31:0];
    if (n[5:3] != 3'b111) begin
      pad_words[14] = bit_len[63:32];
      pad_words[15] = bit_len[31:0];
    end
  end

  // next state, counts and queue push
  always_comb begin
    state_next  = state;
    n_next      = n;
    total_next  = total;
    q_push      = 1'b0;
    q_job.last  = 1'b0;
    q_job.words = fill_words;
    case (state)
      FRONT_TAKE: begin
        if (take) begin
          if (req.req_type == REQ_BYTE) begin
            n_next     = n + 6'd1;
            total_next = total + 61'd1;
            if (n == 6'd63) begin
              q_push = 1'b1;
            end
          end else begin
            q_push      = 1'b1;
            q_job.words = pad_words;
            n_next      = 6'd0;
            if (n[5:3] == 3'b111) begin
              state_next = FRONT_LEN;
            end else begin
              q_job.last = 1'b1;
              total_next = 61'd0;
            end
          end
        end
      end
      FRONT_LEN: begin
        q_job.words = len_words;
        q_job.last  = 1'b1;
        if (!q_full) begin
          q_push     = 1'b1;
          total_next = 61'd0;
          state_next = FRONT_TAKE;
        end
      end
      default: begin
        state_next = FRONT_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_TAKE;
      n     <= 6'd0;
      total <= 61'd0;
    end else begin
      state <= state_next;
      n     <= n_next;
      total <= total_next;
    end
  end

  // block buffer: payload only
  always_ff @(posedge clk) begin
    if (take && (req.req_type == REQ_BYTE)) begin
      blk[idx] <= byte_wd;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sha1bs_queue.sv
`default_nettype none

module sha1bs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sha1bs_pkg::sha1bs_job_t push_job,
  output logic                    full,
  input  logic                    pop,
  output logic                    head_valid,
  output sha1bs_pkg::sha1bs_job_t head_job
);
  import sha1bs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sha1bs_job_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;

  assign full       = (cnt == CNT_W'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head_job   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sha1bs_core.sv
`default_nettype none

module sha1bs_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  sha1bs_pkg::sha1bs_job_t q_job,
  output logic                    q_pop,
  sha1bs_out_if.source            digest
);
  import sha1bs_pkg::*;

  sha1bs_core_state_t state, state_next;
  logic [6:0]         rnd;
  logic [31:0]        a, b, c, d, e;
  logic [15:0][31:0]  win;
  logic [4:0][31:0]   chain;
  logic               last;
  logic               dig_valid;
  logic [63:0]        dig_high, dig_middle;
  logic [31:0]        dig_low;

  logic [31:0]       t, w_new;
  logic [4:0][31:0]  sum;
  logic              fin_go;

  assign digest.valid         = dig_valid;
  assign digest.digest_high   = dig_high;
  assign digest.digest_middle = dig_middle;
  assign digest.digest_low    = dig_low;

  // one round: five-way add, schedule word from the window
  assign t     = {a[26:0], a[31:27]} + sha1_f(rnd, b, c, d) + e + win[0] + sha1_k(rnd);
  assign w_new = {win[13][30:0] ^ win[8][30:0] ^ win[2][30:0] ^ win[0][30:0],
                  win[13][31] ^ win[8][31] ^ win[2][31] ^ win[0][31]};

  assign sum[0] = chain[0] + a;
  assign sum[1] = chain[1] + b;
  assign sum[2] = chain[2] + c;
  assign sum[3] = chain[3] + d;
  assign sum[4] = chain[4] + e;

  // sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    fin_go     = 1'b0;
    case (state)
      CORE_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = CORE_ROUND;
        end
      end
      CORE_ROUND: begin
        if (rnd == 7'(ROUNDS - 1)) begin
          state_next = CORE_FINISH;
        end
      end
      CORE_FINISH: begin
        // a final block waits for the digest slot
        if (!last || !dig_valid || digest.ready) begin
          fin_go     = 1'b1;
          state_next = CORE_IDLE;
        end
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CORE_IDLE;
      chain     <= SHA1_IV;
      dig_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (digest.valid && digest.ready) begin
        dig_valid <= 1'b0;
      end
      if (fin_go) begin
        if (last) begin
          chain     <= SHA1_IV;
          dig_valid <= 1'b1;
        end else begin
          chain <= sum;
        end
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (q_pop) begin
      win  <= q_job.words;
      last <= q_job.last;
      rnd  <= 7'd0;
      a    <= chain[0];
      b    <= chain[1];
      c    <= chain[2];
      d    <= chain[3];
      e    <= chain[4];
    end else if (state == CORE_ROUND) begin
      rnd <= rnd + 7'd1;
      a   <= t;
      b   <= a;
      c   <= {b[1:0], b[31:2]};
      d   <= c;
      e   <= d;
      for (int j = 0; j < 15; j++) begin
        win[j] <= win[j+1];
      end
      win[15] <= w_new;
    end
  end

  // digest register
  always_ff @(posedge clk) begin
    if (fin_go && last) begin
      dig_high   <= {sum[0], sum[1]};
      dig_middle <= {sum[2], sum[3]};
      dig_low    <= sum[4];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sha1_byte_stream_hash.sv
`default_nettype none

// SHA-1 over a byte stream. Each req beat carries one message byte
// (req_type 0) or a finalize (req_type 1). Bytes are packed into a block
// buffer at one per clock while the block queue has room and no length block
// is pending; each full block of 64 bytes goes into a queue of QUEUE_DEPTH
// blocks. The compression core takes a block from the queue and works through
// it in order (load, 80 rounds, one per clock, and the chaining update), so
// the sustained rate is set by the round loop. A finalize queues the padded
// block, plus one length-only block when 56 or more bytes are pending, and
// the digest beat follows once those blocks, and any queued before them, are
// compressed. The digest sits in an output register, so new bytes are taken
// while it waits; the hash state returns to the initial vector after each
// digest.
module sha1_byte_stream_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  sha1bs_in_if.sink    req,
  sha1bs_out_if.source digest
);
  import sha1bs_pkg::*;

  logic               q_push, q_full, q_pop, q_valid;
  sha1bs_job_t        q_in_job, q_head_job;
  sha1bs_front_stat_t fstat;

  sha1bs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_in_job),
    .stat   (fstat)
  );

  sha1bs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  sha1bs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_head_job),
    .q_pop   (q_pop),
    .digest  (digest)
  );

`ifndef NO_ASSERTIONS
  // the front end never overruns the block queue
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("block pushed into a full queue");

  // the core only takes a block that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("block taken from an empty queue");

  // while the length block is pending no beat is taken and the buffer is empty
  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    fstat.len_pend |-> (!req.ready && fstat.block_empty))
    else $error("request taken while length block pending");

  // a finalize always leaves an empty block buffer
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.req_type == REQ_FINAL)) |=> fstat.block_empty)
    else $error("block buffer not cleared by finalize");
`endif

endmodule

`default_nettype wire

### tb/sha1bs_digest_checker.sv
`timescale 1ns / 1ps

// Watches both channels, runs a software SHA-1 alongside the block and
// compares every digest beat with the oldest digest still owed.
module sha1bs_digest_checker (
  input  logic         clk,
  input  logic         rst,
  sha1bs_in_if         req,
  sha1bs_out_if        digest,
  output int           fail_count,
  output int           pending,
  output int           digests_seen
);
  import sha1bs_pkg::*;

  typedef struct packed {
    logic [63:0] hi_pair;   // words 0 and 1
    logic [63:0] mid_pair;  // words 2 and 3
    logic [31:0] low_word;  // word 4
  } digest_beat_t;

  // shadow hash state
  logic [31:0] chain_w [5];
  logic [31:0] blk_w [16];
  logic [5:0]  blk_fill;
  logic [60:0] msg_bytes;

  digest_beat_t digests_due [$];

  function automatic void restart_chain();
    for (int i = 0; i < 5; i++) chain_w[i] = SHA1_IV[i];
    blk_fill  = '0;
    msg_bytes = '0;
  endfunction

  // 80 rounds over blk_w, folded into chain_w
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wi, t;
    w = blk_w;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    e = chain_w[4];
    for (int i = 0; i < ROUNDS; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        t  = w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16];
        wi = {t[30:0], t[31]};
        w[i % 16] = wi;
      end
      case (i / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = SHA1_K0;
        end
        1: begin
          f = b ^ c ^ d;
          k = SHA1_K1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = SHA1_K2;
        end
        default: begin
          f = b ^ c ^ d;
          k = SHA1_K3;
        end
      endcase
      t = {a[26:0], a[31:27]} + f + e + wi + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
    chain_w[4] += e;
  endfunction

  // pack one message byte big-endian; a full block is compressed at once
  function automatic void absorb_byte(input logic [7:0] value);
    int idx;
    int sh;
    idx = blk_fill[5:2];
    sh  = 24 - 8 * int'(blk_fill[1:0]);
    if (blk_fill[1:0] == 2'd0) begin
      blk_w[idx] = {value, 24'h0};
    end else begin
      blk_w[idx][sh +: 8] = value;
    end
    msg_bytes = msg_bytes + 61'd1;
    if (blk_fill == 6'd63) compress_block();
    blk_fill = blk_fill + 6'd1;
  endfunction

  // pad, append the bit length, compress and hand back the digest
  function automatic digest_beat_t close_message();
    digest_beat_t dg;
    logic [63:0]  bit_len;
    int idx;
    int sh;
    idx = blk_fill[5:2];
    sh  = 24 - 8 * int'(blk_fill[1:0]);
    if (blk_fill[1:0] == 2'd0) begin
      blk_w[idx] = 32'h8000_0000;
    end else begin
      blk_w[idx] = (blk_w[idx] & ~(32'hffff_ffff >> (24 - sh))) | (32'h80 << sh);
    end
    for (int i = idx + 1; i < 16; i++) blk_w[i] = '0;
    // no room for the length: spill into a length-only block
    if (blk_fill >= 6'd56) begin
      compress_block();
      for (int i = 0; i < 14; i++) blk_w[i] = '0;
    end
    bit_len   = {msg_bytes, 3'b000};
    blk_w[14] = bit_len[63:32];
    blk_w[15] = bit_len[31:0];
    compress_block();
    dg.hi_pair  = {chain_w[0], chain_w[1]};
    dg.mid_pair = {chain_w[2], chain_w[3]};
    dg.low_word = chain_w[4];
    restart_chain();
    return dg;
  endfunction

  function automatic void check_field(input string label, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("[%0t] %s mismatch: expected %h, got %h", $time, label, want, got);
    end
  endfunction

  // digest beats are checked before the request beat of the same edge is
  // predicted; a digest can never belong to a finalize taken on that edge
  always @(posedge clk) begin
    digest_beat_t got;
    digest_beat_t want;
    if (rst) begin
      restart_chain();
      for (int i = 0; i < 16; i++) blk_w[i] = '0;
      digests_due.delete();
      fail_count   = 0;
      digests_seen = 0;
    end else begin
      if (digest.valid && digest.ready) begin
        got.hi_pair  = digest.digest_high;
        got.mid_pair = digest.digest_middle;
        got.low_word = digest.digest_low;
        digests_seen++;
        if (digests_due.size() == 0) begin
          fail_count++;
          $display("[%0t] digest beat with none owed: got %h %h %h", $time,
                   got.hi_pair, got.mid_pair, got.low_word);
        end else begin
          want = digests_due.pop_front();
          check_field("digest_high", want.hi_pair, got.hi_pair);
          check_field("digest_middle", want.mid_pair, got.mid_pair);
          check_field("digest_low", {32'h0, want.low_word}, {32'h0, got.low_word});
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_FINAL) begin
          digests_due.push_back(close_message());
        end else begin
          absorb_byte(req.data_byte);
        end
      end
    end
    pending = digests_due.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sha1bs_pkg::*;

  localparam int HOLD_CYCLES    = 1500;
  // quiet spell allowed: the hold-off plus a handful of queued blocks
  localparam int WATCHDOG_LIMIT = 10000;

  logic clk;
  logic rst;

  sha1bs_in_if  req_ch ();
  sha1bs_out_if dig_ch ();

  int mismatches;
  int owed;
  int digests_seen;

  bit hold_request;
  int bytes_sent;
  int messages_sent;
  int empty_messages;
  int length_spills;

  sha1_byte_stream_hash dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch.sink),
    .digest (dig_ch.source)
  );

  sha1bs_digest_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .digest       (dig_ch),
    .fail_count   (mismatches),
    .pending      (owed),
    .digests_seen (digests_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request beat; returns on the negedge after acceptance
  task automatic send_beat(input logic kind, input logic [7:0] value, input bit brisk);
    int gap;
    gap = brisk ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.data_byte <= value;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit brisk);
    for (int i = 0; i < len; i++) begin
      send_beat(REQ_BYTE, 8'($urandom), brisk);
    end
    // data on a finalize is don't-care, so keep it random
    send_beat(REQ_FINAL, 8'($urandom), brisk);
    bytes_sent += len;
    messages_sent++;
    if (len == 0) empty_messages++;
    if (len % 64 >= 56) length_spills++;
  endtask

  // digest side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    dig_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        dig_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          dig_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        dig_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
          @(negedge clk);
      end
    end
  end

  // watchdog: ends the run if nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] timeout: no beat for %0d cycles, %0d digests owed", $time, quiet, owed);
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int len;
    int roll;
    int boundary [8];
    boundary         = '{55, 56, 57, 63, 64, 65, 119, 120};
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_BYTE;
    req_ch.data_byte = 8'h00;
    hold_request     = 1'b0;
    bytes_sent       = 0;
    messages_sent    = 0;
    empty_messages   = 0;
    length_spills    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message twice back to back, then extreme and known bytes
    send_beat(REQ_FINAL, 8'hff, 1'b1);
    send_beat(REQ_FINAL, 8'h00, 1'b1);
    messages_sent  += 2;
    empty_messages += 2;
    send_beat(REQ_BYTE, 8'h00, 1'b0);
    send_beat(REQ_BYTE, 8'hff, 1'b0);
    send_beat(REQ_FINAL, 8'h00, 1'b0);
    send_beat(REQ_BYTE, 8'h61, 1'b1);
    send_beat(REQ_BYTE, 8'h62, 1'b1);
    send_beat(REQ_BYTE, 8'h63, 1'b1);
    send_beat(REQ_FINAL, 8'h00, 1'b1);
    send_beat(REQ_BYTE, 8'h80, 1'b0);
    send_beat(REQ_FINAL, 8'h55, 1'b0);
    messages_sent += 3;
    bytes_sent    += 6;
    send_message(56, 1'b1);
    send_message(64, 1'b1);

    // random: block the digest side early so the block backs up
    hold_request = 1'b1;
    for (int m = 0; m < 6; m++) send_message($urandom_range(20, 70), 1'b1);
    while (bytes_sent + messages_sent < 800) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        len = $urandom_range(0, 3);
      end else if (roll < 7) begin
        len = boundary[$urandom_range(0, 7)];
      end else if (roll < 8) begin
        len = $urandom_range(100, 200);
      end else begin
        len = $urandom_range(0, 70);
      end
      send_message(len, $urandom_range(0, 3) == 0);
    end
    req_ch.valid <= 1'b0;

    // drain, then keep watching for stray beats
    while (owed != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d messages, %0d bytes, %0d empty, %0d needing a length-only block",
             messages_sent, bytes_sent, empty_messages, length_spills);
    $display("%0d digests checked; digest side held off %0d cycles with input backed up",
             digests_seen, HOLD_CYCLES);
    if (mismatches == 0 && owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
